/* rtl/core/tcap_pkg.sv */
// ----------------------------------------------------------------------------
// tcap_pkg
// Shared constants for the two-track closest approach point pipeline:
// default field geometry and the partial-product slicing of the multipliers.
// ----------------------------------------------------------------------------
package tcap_pkg;

  // default position width and slope fraction bits
  localparam int POS_BITS_DEF        = 26;
  localparam int SLOPE_FRAC_BITS_DEF = 20;

  // multiplier slicing: unsigned digits of this many bits, 32x32 signed partial products
  localparam int MUL_CHUNK = 31;
  localparam int MUL_DIG   = MUL_CHUNK + 1;
  // register stages through one multiplier
  localparam int MUL_LAT   = 3;

endpackage

/* rtl/core/tcap_mul.sv */
// ----------------------------------------------------------------------------
// tcap_mul
// Pipelined signed multiplier built from 32x32 partial products:
// partial products, row sums, final sum, one register stage each.
// ----------------------------------------------------------------------------
module tcap_mul import tcap_pkg::*; #(
  parameter int AW = 23,
  parameter int BW = 23
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int PW  = AW + BW;
  localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AEW = NA * MUL_CHUNK;
  localparam int BEW = NB * MUL_CHUNK;

  logic signed [AEW-1:0]       a_ext;
  logic signed [BEW-1:0]       b_ext;
  logic signed [MUL_DIG-1:0]   a_dig [NA];
  logic signed [MUL_DIG-1:0]   b_dig [NB];
  logic signed [2*MUL_DIG-1:0] pp_q  [NA][NB];
  logic signed [PW-1:0]        row_d [NB];
  logic signed [PW-1:0]        row_q [NB];
  logic signed [PW-1:0]        p_d;
  logic signed [PW-1:0]        p_q;

  assign a_ext = AEW'(a_i);
  assign b_ext = BEW'(b_i);

  // split into unsigned low digits and a signed top digit
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        a_dig[i] = {a_ext[i*MUL_CHUNK+MUL_CHUNK-1], a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
      end else begin
        a_dig[i] = {1'b0, a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        b_dig[j] = {b_ext[j*MUL_CHUNK+MUL_CHUNK-1], b_ext[j*MUL_CHUNK +: MUL_CHUNK]};
      end else begin
        b_dig[j] = {1'b0, b_ext[j*MUL_CHUNK +: MUL_CHUNK]};
      end
    end
  end

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_dig[i] * b_dig[j];
        end
      end
    end
  end

  // row sums, modulo the product width
  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_d[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_d[j] = row_d[j] + (PW'(pp_q[i][j]) <<< (MUL_CHUNK * i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  // final sum
  always_comb begin
    p_d = '0;
    for (int j = 0; j < NB; j++) begin
      p_d = p_d + (row_q[j] <<< (MUL_CHUNK * j));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

/* rtl/core/tcap_div.sv */
// ----------------------------------------------------------------------------
// tcap_div
// Pipelined rounding divider: round(num / (2*den)), ties away from zero,
// saturated to the signed PB-bit range. One quotient bit per stage.
// ----------------------------------------------------------------------------
module tcap_div #(
  parameter int PB   = 26,
  parameter int NUMW = 124,
  parameter int DW   = 94
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [NUMW-1:0] num_i,
  input  logic [DW-1:0]          den_i,
  output logic signed [PB-1:0]   quo_o
);

  localparam int RW = ((NUMW + 1) > (DW + PB + 1)) ? (NUMW + 1) : (DW + PB + 1);
  localparam logic [PB-1:0] HALF = PB'(1) << (PB - 1);

  logic [NUMW-1:0] mag_q;
  logic            neg0_q;
  logic [DW-1:0]   den0_q;

  logic [RW-1:0]   rem_q  [PB+1];
  logic [PB-1:0]   quo_q  [PB+1];
  logic [DW-1:0]   den_q  [PB+1];
  logic            neg_q  [PB+1];
  logic            huge_q [PB+1];
  logic [RW-1:0]   sh     [PB];
  logic            take   [PB];
  logic [RW-1:0]   lim;
  logic [PB-1:0]   qv;
  logic [PB-1:0]   res_d;
  logic [PB-1:0]   res_q;

  // magnitude and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg0_q <= num_i[NUMW-1];
      mag_q  <= num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
      den0_q <= den_i;
    end
  end

  // divisor shifted to each quotient bit position, and the overflow limit
  always_comb begin
    for (int s = 0; s < PB; s++) begin
      sh[s]   = RW'(den_q[s]) << (PB - s);
      take[s] = rem_q[s] >= sh[s];
    end
    lim = RW'(den_q[0]) << (PB + 1);
  end

  // add half the divisor, then one restoring step per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RW'(mag_q) + RW'(den0_q);
      quo_q[0]  <= '0;
      den_q[0]  <= den0_q;
      neg_q[0]  <= neg0_q;
      huge_q[0] <= 1'b0;
      for (int s = 0; s < PB; s++) begin
        rem_q[s+1]  <= take[s] ? (rem_q[s] - sh[s]) : rem_q[s];
        quo_q[s+1]  <= take[s] ? (quo_q[s] | (PB'(1) << (PB - 1 - s))) : quo_q[s];
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        huge_q[s+1] <= (s == 0) ? (rem_q[0] >= lim) : huge_q[s];
      end
    end
  end

  // sign and saturation
  assign qv = quo_q[PB];

  always_comb begin
    if (neg_q[PB]) begin
      if (huge_q[PB] || (qv > HALF)) begin
        res_d = HALF;
      end else begin
        res_d = PB'(-qv);
      end
    end else begin
      if (huge_q[PB] || qv[PB-1]) begin
        res_d = HALF - PB'(1);
      end else begin
        res_d = qv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

/* rtl/core/two_track_closest_approach_point_top.sv */
// Throughput: one track pair per cycle; the pipeline advances whenever the output
//   register is empty or taken; a one-entry skid buffer takes one pair during a stall.
// Depth is set by three levels of 3-stage multipliers and the divider, which
//   resolves one quotient bit per stage.
// Reset clears the valid bits of the pipeline and the skid buffer.
// ----------------------------------------------------------------------------
// two_track_closest_approach_point_top
// Midpoint of the closest approach of two straight tracks, exact integer
// intermediates, one rounded and saturated division per coordinate.
// ----------------------------------------------------------------------------
module two_track_closest_approach_point_top import tcap_pkg::*; #(
  parameter int POS_BITS        = POS_BITS_DEF,
  parameter int SLOPE_FRAC_BITS = SLOPE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [POS_BITS-1:0]          a_x_i,
  input  logic signed [POS_BITS-1:0]          a_y_i,
  input  logic signed [POS_BITS-1:0]          a_z_i,
  input  logic signed [SLOPE_FRAC_BITS+2:0]   a_tx_i,
  input  logic signed [SLOPE_FRAC_BITS+2:0]   a_ty_i,
  input  logic signed [POS_BITS-1:0]          b_x_i,
  input  logic signed [POS_BITS-1:0]          b_y_i,
  input  logic signed [POS_BITS-1:0]          b_z_i,
  input  logic signed [SLOPE_FRAC_BITS+2:0]   b_tx_i,
  input  logic signed [SLOPE_FRAC_BITS+2:0]   b_ty_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [POS_BITS-1:0]          mid_x_o,
  output logic signed [POS_BITS-1:0]          mid_y_o,
  output logic signed [POS_BITS-1:0]          mid_z_o,
  output logic                                valid_res_o
);

  localparam int PB   = POS_BITS;
  localparam int F    = SLOPE_FRAC_BITS;
  localparam int SW   = SLOPE_FRAC_BITS + 3;
  localparam int AAW  = 2 * SW + 1;
  localparam int FW   = SW + PB + 2;
  localparam int DW   = 4 * SW + 2;
  localparam int NW   = AAW + FW + 1;
  localparam int N1W  = PB + 1 + DW;
  localparam int N2W  = NW + SW;
  localparam int NUMW = ((N1W > N2W) ? N1W : N2W) + 2;
  localparam int IW   = 6 * PB + 4 * SW;

  localparam int SUM_DLY  = 2 * (MUL_LAT + 1);
  localparam int DIV_LAT  = PB + 3;
  localparam int PIPE_LEN = 2 + 3 * (MUL_LAT + 1) + DIV_LAT;

  localparam logic signed [AAW-1:0] SS = AAW'(1) <<< (2 * F);

  // --------------------------------------------------------------------------
  // flow control: global advance, skid buffer in front
  // --------------------------------------------------------------------------
  logic                en;
  logic [PIPE_LEN-1:0] v_q;
  logic                skid_v_q;
  logic [IW-1:0]       skid_q;
  logic [IW-1:0]       in_vec;
  logic [IW-1:0]       head_vec;
  logic                head_v;

  assign en         = !v_q[PIPE_LEN-1] || out_ready_i;
  assign in_ready_o = !skid_v_q;
  assign in_vec     = {a_x_i, a_y_i, a_z_i, a_tx_i, a_ty_i,
                       b_x_i, b_y_i, b_z_i, b_tx_i, b_ty_i};
  assign head_vec   = skid_v_q ? skid_q : in_vec;
  assign head_v     = skid_v_q || in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en) begin
      skid_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && in_ready_o) begin
      skid_q <= in_vec;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_LEN-2:0], head_v};
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: input register
  // --------------------------------------------------------------------------
  logic [IW-1:0] in0_q;
  logic signed [PB-1:0] ax0, ay0, az0, bx0, by0, bz0;
  logic signed [SW-1:0] atx0, aty0, btx0, bty0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in0_q <= head_vec;
    end
  end

  assign {ax0, ay0, az0, atx0, aty0, bx0, by0, bz0, btx0, bty0} = in0_q;

  // --------------------------------------------------------------------------
  // stage 1: differences and sums of reference points
  // --------------------------------------------------------------------------
  logic signed [PB:0]     dx1_q, dy1_q, dz1_q;
  logic [3*(PB+1)-1:0]    pos1_q;
  logic [4*SW-1:0]        slp1_q;
  logic signed [SW-1:0]   atx1, aty1, btx1, bty1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q  <= (PB+1)'(ax0) - (PB+1)'(bx0);
      dy1_q  <= (PB+1)'(ay0) - (PB+1)'(by0);
      dz1_q  <= (PB+1)'(az0) - (PB+1)'(bz0);
      pos1_q <= {(PB+1)'(ax0) + (PB+1)'(bx0),
                 (PB+1)'(ay0) + (PB+1)'(by0),
                 (PB+1)'(az0) + (PB+1)'(bz0)};
      slp1_q <= {atx0, aty0, btx0, bty0};
    end
  end

  assign {atx1, aty1, btx1, bty1} = slp1_q;

  // --------------------------------------------------------------------------
  // first multiplier level: slope products and slope times offset
  // --------------------------------------------------------------------------
  logic signed [2*SW-1:0]  p_aa1, p_aa2, p_bb1, p_bb2, p_ab1, p_ab2;
  logic signed [SW+PB:0]   p_fa1, p_fa2, p_fb1, p_fb2;

  tcap_mul #(.AW(SW), .BW(SW)) u_mul_aa1 (
    .clk_i, .en_i(en), .a_i(atx1), .b_i(atx1), .p_o(p_aa1));
  tcap_mul #(.AW(SW), .BW(SW)) u_mul_aa2 (
    .clk_i, .en_i(en), .a_i(aty1), .b_i(aty1), .p_o(p_aa2));
  tcap_mul #(.AW(SW), .BW(SW)) u_mul_bb1 (
    .clk_i, .en_i(en), .a_i(btx1), .b_i(btx1), .p_o(p_bb1));
  tcap_mul #(.AW(SW), .BW(SW)) u_mul_bb2 (
    .clk_i, .en_i(en), .a_i(bty1), .b_i(bty1), .p_o(p_bb2));
  tcap_mul #(.AW(SW), .BW(SW)) u_mul_ab1 (
    .clk_i, .en_i(en), .a_i(atx1), .b_i(btx1), .p_o(p_ab1));
  tcap_mul #(.AW(SW), .BW(SW)) u_mul_ab2 (
    .clk_i, .en_i(en), .a_i(aty1), .b_i(bty1), .p_o(p_ab2));
  tcap_mul #(.AW(SW), .BW(PB+1)) u_mul_fa1 (
    .clk_i, .en_i(en), .a_i(atx1), .b_i(dx1_q), .p_o(p_fa1));
  tcap_mul #(.AW(SW), .BW(PB+1)) u_mul_fa2 (
    .clk_i, .en_i(en), .a_i(aty1), .b_i(dy1_q), .p_o(p_fa2));
  tcap_mul #(.AW(SW), .BW(PB+1)) u_mul_fb1 (
    .clk_i, .en_i(en), .a_i(btx1), .b_i(dx1_q), .p_o(p_fb1));
  tcap_mul #(.AW(SW), .BW(PB+1)) u_mul_fb2 (
    .clk_i, .en_i(en), .a_i(bty1), .b_i(dy1_q), .p_o(p_fb2));

  // dz alongside the multipliers
  logic signed [PB:0] dz_dly_q [MUL_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dz_dly_q[0] <= dz1_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        dz_dly_q[k] <= dz_dly_q[k-1];
      end
    end
  end

  // sums and slopes travel to the third multiplier level
  logic [3*(PB+1)-1:0] pos_dly_q [SUM_DLY];
  logic [4*SW-1:0]     slp_dly_q [SUM_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_dly_q[0] <= pos1_q;
      slp_dly_q[0] <= slp1_q;
      for (int k = 1; k < SUM_DLY; k++) begin
        pos_dly_q[k] <= pos_dly_q[k-1];
        slp_dly_q[k] <= slp_dly_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // normal equation coefficients and right-hand sides
  // --------------------------------------------------------------------------
  logic signed [AAW-1:0] aa5_q, bb5_q, ab5_q;
  logic signed [FW-1:0]  fa5_q, fb5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      aa5_q <= AAW'(p_aa1) + AAW'(p_aa2) + SS;
      bb5_q <= AAW'(p_bb1) + AAW'(p_bb2) + SS;
      ab5_q <= -(AAW'(p_ab1) + AAW'(p_ab2) + SS);
      fa5_q <= FW'(p_fa1) + FW'(p_fa2) + (FW'(dz_dly_q[MUL_LAT-1]) <<< F);
      fb5_q <= -(FW'(p_fb1) + FW'(p_fb2) + (FW'(dz_dly_q[MUL_LAT-1]) <<< F));
    end
  end

  // --------------------------------------------------------------------------
  // second multiplier level: determinant and numerators
  // --------------------------------------------------------------------------
  logic signed [2*AAW-1:0]  p_aabb, p_abab;
  logic signed [AAW+FW-1:0] p_abfb, p_bbfa, p_abfa, p_aafb;

  tcap_mul #(.AW(AAW), .BW(AAW)) u_mul_aabb (
    .clk_i, .en_i(en), .a_i(aa5_q), .b_i(bb5_q), .p_o(p_aabb));
  tcap_mul #(.AW(AAW), .BW(AAW)) u_mul_abab (
    .clk_i, .en_i(en), .a_i(ab5_q), .b_i(ab5_q), .p_o(p_abab));
  tcap_mul #(.AW(AAW), .BW(FW)) u_mul_abfb (
    .clk_i, .en_i(en), .a_i(ab5_q), .b_i(fb5_q), .p_o(p_abfb));
  tcap_mul #(.AW(AAW), .BW(FW)) u_mul_bbfa (
    .clk_i, .en_i(en), .a_i(bb5_q), .b_i(fa5_q), .p_o(p_bbfa));
  tcap_mul #(.AW(AAW), .BW(FW)) u_mul_abfa (
    .clk_i, .en_i(en), .a_i(ab5_q), .b_i(fa5_q), .p_o(p_abfa));
  tcap_mul #(.AW(AAW), .BW(FW)) u_mul_aafb (
    .clk_i, .en_i(en), .a_i(aa5_q), .b_i(fb5_q), .p_o(p_aafb));

  logic signed [DW-1:0] d9_q;
  logic signed [NW-1:0] na9_q, nb9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d9_q  <= DW'(p_aabb) - DW'(p_abab);
      na9_q <= NW'(p_abfb) - NW'(p_bbfa);
      nb9_q <= NW'(p_abfa) - NW'(p_aafb);
    end
  end

  logic signed [PB:0]   sx9, sy9, sz9;
  logic signed [SW-1:0] atx9, aty9, btx9, bty9;

  assign {sx9, sy9, sz9}        = pos_dly_q[SUM_DLY-1];
  assign {atx9, aty9, btx9, bty9} = slp_dly_q[SUM_DLY-1];

  // --------------------------------------------------------------------------
  // third multiplier level: numerator terms of the midpoint
  // --------------------------------------------------------------------------
  logic signed [PB+DW:0]  p_sxd, p_syd, p_szd;
  logic signed [NW+SW-1:0] p_nax, p_nbx, p_nay, p_nby;

  tcap_mul #(.AW(PB+1), .BW(DW)) u_mul_sxd (
    .clk_i, .en_i(en), .a_i(sx9), .b_i(d9_q), .p_o(p_sxd));
  tcap_mul #(.AW(PB+1), .BW(DW)) u_mul_syd (
    .clk_i, .en_i(en), .a_i(sy9), .b_i(d9_q), .p_o(p_syd));
  tcap_mul #(.AW(PB+1), .BW(DW)) u_mul_szd (
    .clk_i, .en_i(en), .a_i(sz9), .b_i(d9_q), .p_o(p_szd));
  tcap_mul #(.AW(NW), .BW(SW)) u_mul_nax (
    .clk_i, .en_i(en), .a_i(na9_q), .b_i(atx9), .p_o(p_nax));
  tcap_mul #(.AW(NW), .BW(SW)) u_mul_nbx (
    .clk_i, .en_i(en), .a_i(nb9_q), .b_i(btx9), .p_o(p_nbx));
  tcap_mul #(.AW(NW), .BW(SW)) u_mul_nay (
    .clk_i, .en_i(en), .a_i(na9_q), .b_i(aty9), .p_o(p_nay));
  tcap_mul #(.AW(NW), .BW(SW)) u_mul_nby (
    .clk_i, .en_i(en), .a_i(nb9_q), .b_i(bty9), .p_o(p_nby));

  // numerator sum for z and the parallel-track flag, beside the multipliers
  logic signed [NW:0]   nn10_q;
  logic                 zero10_q;
  logic signed [NW:0]   nn_dly_q   [MUL_LAT-1];
  logic                 zero_dly_q [MUL_LAT-1];
  logic signed [DW-1:0] d_dly_q    [MUL_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      nn10_q        <= (NW+1)'(na9_q) + (NW+1)'(nb9_q);
      zero10_q      <= (d9_q == '0);
      nn_dly_q[0]   <= nn10_q;
      zero_dly_q[0] <= zero10_q;
      for (int k = 1; k < MUL_LAT - 1; k++) begin
        nn_dly_q[k]   <= nn_dly_q[k-1];
        zero_dly_q[k] <= zero_dly_q[k-1];
      end
      d_dly_q[0] <= d9_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        d_dly_q[k] <= d_dly_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // midpoint numerators, twice the midpoint times the determinant
  // --------------------------------------------------------------------------
  logic signed [NUMW-1:0] numx13_q, numy13_q, numz13_q;
  logic [DW-1:0]          d13_q;
  logic                   zero13_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx13_q <= NUMW'(p_sxd) + NUMW'(p_nax) + NUMW'(p_nbx);
      numy13_q <= NUMW'(p_syd) + NUMW'(p_nay) + NUMW'(p_nby);
      numz13_q <= NUMW'(p_szd) + (NUMW'(nn_dly_q[MUL_LAT-2]) <<< F);
      d13_q    <= d_dly_q[MUL_LAT-1];
      zero13_q <= zero_dly_q[MUL_LAT-2];
    end
  end

  // --------------------------------------------------------------------------
  // rounding dividers
  // --------------------------------------------------------------------------
  logic signed [PB-1:0] qx, qy, qz;

  tcap_div #(.PB(PB), .NUMW(NUMW), .DW(DW)) u_div_x (
    .clk_i, .en_i(en), .num_i(numx13_q), .den_i(d13_q), .quo_o(qx));
  tcap_div #(.PB(PB), .NUMW(NUMW), .DW(DW)) u_div_y (
    .clk_i, .en_i(en), .num_i(numy13_q), .den_i(d13_q), .quo_o(qy));
  tcap_div #(.PB(PB), .NUMW(NUMW), .DW(DW)) u_div_z (
    .clk_i, .en_i(en), .num_i(numz13_q), .den_i(d13_q), .quo_o(qz));

  logic zero_out_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_out_q[0] <= zero13_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        zero_out_q[k] <= zero_out_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // result; parallel tracks give a cleared midpoint
  // --------------------------------------------------------------------------
  assign out_valid_o = v_q[PIPE_LEN-1];
  assign valid_res_o = !zero_out_q[DIV_LAT-1];
  assign mid_x_o     = zero_out_q[DIV_LAT-1] ? '0 : qx;
  assign mid_y_o     = zero_out_q[DIV_LAT-1] ? '0 : qy;
  assign mid_z_o     = zero_out_q[DIV_LAT-1] ? '0 : qz;

endmodule

/* bench/tb_two_track_closest_approach_point_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_track_closest_approach_point_top
// Self-checking bench for the closest approach midpoint pipeline. A directed
// table covers parallel tracks, field extremes and a known crossing, then
// random track pairs (generic, parallel, near parallel, small offsets, corner values) are
// checked against a wide-integer midpoint calculator under random idling and
// one long output stall.
// ----------------------------------------------------------------------------
module tb_two_track_closest_approach_point_top import tcap_pkg::*; ();

  localparam int PB       = POS_BITS_DEF;
  localparam int SFB      = SLOPE_FRAC_BITS_DEF;
  localparam int SB       = SFB + 3;
  localparam int N_RAND   = 1800;
  localparam int LATENCY  = PB + 17;
  localparam int LIMIT    = 400000;

  typedef logic signed [191:0]  wide_t;
  typedef logic signed [PB-1:0] pos_t;
  typedef logic signed [SB-1:0] slope_t;

  typedef struct {
    pos_t   ax, ay, az;
    slope_t atx, aty;
    pos_t   bx, by, bz;
    slope_t btx, bty;
  } pair_t;

  typedef struct {
    pos_t mx, my, mz;
    logic ok;
  } mid_t;

  typedef struct {
    pair_t p;
    bit    typed;
    mid_t  r;
  } row_t;

  logic   clk_i, rst_ni;
  logic   in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  pos_t   a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i;
  slope_t a_tx_i, a_ty_i, b_tx_i, b_ty_i;
  pos_t   mid_x_o, mid_y_o, mid_z_o;
  logic   valid_res_o;

  two_track_closest_approach_point_top dut (.*);

  mid_t   midpoint_q[$];
  int     n_fail, n_sent, n_seen, n_parallel, cycles;
  bit     long_stall_done;

  // clock, reset and cycle watchdog
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_two_track_closest_approach_point_top NOT OK");
      $finish;
    end
  end

  // rounded, saturated quotient num / (2d)
  function automatic pos_t div_round(wide_t num, wide_t d);
    wide_t half, mag, q;
    half = wide_t'(1) <<< (PB - 1);
    mag  = (num < 0) ? -num : num;
    q    = (mag + d) / (d + d);
    if (num < 0) begin
      if (q > half) q = half;
      return pos_t'(-q);
    end
    if (q > half - 1) q = half - 1;
    return pos_t'(q);
  endfunction

  // exact closest approach midpoint of one track pair
  function automatic mid_t closest_midpoint(pair_t p);
    wide_t xa, ya, za, txa, tya, xb, yb, zb, txb, tyb;
    wide_t s, ss, aa, bb, ab, d, dx, dy, dz, fa, fb, na, nb;
    mid_t  r;
    xa = p.ax; ya = p.ay; za = p.az; txa = p.atx; tya = p.aty;
    xb = p.bx; yb = p.by; zb = p.bz; txb = p.btx; tyb = p.bty;
    s  = wide_t'(1) <<< SFB;
    ss = s * s;
    aa = txa * txa + tya * tya + ss;
    bb = txb * txb + tyb * tyb + ss;
    ab = -(txa * txb + tya * tyb + ss);
    d  = aa * bb - ab * ab;
    r  = '{mx: '0, my: '0, mz: '0, ok: 1'b0};
    if (d == 0) return r;
    dx = xa - xb; dy = ya - yb; dz = za - zb;
    fa = txa * dx + tya * dy + s * dz;
    fb = -(txb * dx + tyb * dy + s * dz);
    na = ab * fb - bb * fa;
    nb = ab * fa - aa * fb;
    r.mx = div_round((xa + xb) * d + na * txa + nb * txb, d);
    r.my = div_round((ya + yb) * d + na * tya + nb * tyb, d);
    r.mz = div_round((za + zb) * d + s * (na + nb), d);
    r.ok = 1'b1;
    return r;
  endfunction

  // random position / slope, biased toward corners on request
  function automatic pos_t rand_pos(bit corner);
    if (corner)
      case ($urandom_range(0, 4))
        0: return {1'b0, {(PB-1){1'b1}}};
        1: return {1'b1, {(PB-1){1'b0}}};
        2: return '0;
        3: return '1;
        default: ;
      endcase
    return pos_t'($urandom());
  endfunction

  function automatic slope_t rand_slope(bit corner);
    if (corner)
      case ($urandom_range(0, 4))
        0: return {1'b0, {(SB-1){1'b1}}};
        1: return {1'b1, {(SB-1){1'b0}}};
        2: return '0;
        3: return slope_t'(1 << SFB);
        default: ;
      endcase
    return slope_t'($urandom());
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    kind;
    bit    c;
    kind = $urandom_range(0, 99);
    c    = (kind >= 85);
    p.ax = rand_pos(c); p.ay = rand_pos(c); p.az = rand_pos(c);
    p.bx = rand_pos(c); p.by = rand_pos(c); p.bz = rand_pos(c);
    p.atx = rand_slope(c); p.aty = rand_slope(c);
    p.btx = rand_slope(c); p.bty = rand_slope(c);
    if (kind < 15) begin
      // parallel tracks
      p.btx = p.atx; p.bty = p.aty;
    end else if (kind < 28) begin
      // nearly parallel, large midpoint excursions
      p.btx = p.atx + slope_t'($urandom_range(0, 6)) - slope_t'(3);
      p.bty = p.aty + slope_t'($urandom_range(0, 2)) - slope_t'(1);
    end else if (kind < 40) begin
      // small, realistic offsets
      p.ax = pos_t'($signed($urandom_range(0, 20000)) - 10000);
      p.bx = pos_t'($signed($urandom_range(0, 20000)) - 10000);
      p.ay = pos_t'($signed($urandom_range(0, 20000)) - 10000);
      p.by = pos_t'($signed($urandom_range(0, 20000)) - 10000);
    end
    return p;
  endfunction

  function automatic pair_t mk(int ax, ay, az, atx, aty, bx, by, bz, btx, bty);
    pair_t p;
    p.ax = pos_t'(ax); p.ay = pos_t'(ay); p.az = pos_t'(az);
    p.atx = slope_t'(atx); p.aty = slope_t'(aty);
    p.bx = pos_t'(bx); p.by = pos_t'(by); p.bz = pos_t'(bz);
    p.btx = slope_t'(btx); p.bty = slope_t'(bty);
    return p;
  endfunction

  // check one output transaction against the oldest pending midpoint
  always @(posedge clk_i) begin
    mid_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_seen++;
      if (midpoint_q.size() == 0) begin
        $error("result with no pending midpoint");
        n_fail++;
      end else begin
        e = midpoint_q.pop_front();
        if (!e.ok) n_parallel++;
        if (mid_x_o !== e.mx) begin
          $error("mid_x expected %0d got %0d", e.mx, mid_x_o); n_fail++;
        end
        if (mid_y_o !== e.my) begin
          $error("mid_y expected %0d got %0d", e.my, mid_y_o); n_fail++;
        end
        if (mid_z_o !== e.mz) begin
          $error("mid_z expected %0d got %0d", e.mz, mid_z_o); n_fail++;
        end
        if (valid_res_o !== e.ok) begin
          $error("valid_res expected %0d got %0d", e.ok, valid_res_o);
          n_fail++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off once the pipe is busy
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_stall_done && n_sent >= 300) begin
        out_ready_i <= 1'b0;
        long_stall_done = 1'b1;
        repeat (400) @(posedge clk_i);
      end
      gap = $urandom_range(0, 99);
      if (gap < 40) gap = 0;
      else if (gap < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if ((n_sent / 250) % 3 == 2) gap = 0;
      if (gap == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end
    end
  end

  // sender: directed table, then random pairs
  task automatic send(pair_t p, bit typed, mid_t r);
    int gap;
    in_valid_i <= 1'b1;
    a_x_i <= p.ax; a_y_i <= p.ay; a_z_i <= p.az; a_tx_i <= p.atx; a_ty_i <= p.aty;
    b_x_i <= p.bx; b_y_i <= p.by; b_z_i <= p.bz; b_tx_i <= p.btx; b_ty_i <= p.bty;
    do @(posedge clk_i); while (!in_ready_o);
    midpoint_q.push_back(typed ? r : closest_midpoint(p));
    n_sent++;
    gap = $urandom_range(0, 99);
    if (gap < 45 || (n_sent / 250) % 3 == 1) gap = 0;
    else if (gap < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    row_t dir_rows[$];
    mid_t zero_mid, none;
    int   pmax, pmin, tmax, tmin, one;
    in_valid_i = 1'b0;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i} = '0;
    {a_tx_i, a_ty_i, b_tx_i, b_ty_i} = '0;
    n_fail = 0; n_sent = 0; n_seen = 0; n_parallel = 0; cycles = 0;
    pmax = (1 << (PB - 1)) - 1; pmin = -(1 << (PB - 1));
    tmax = (1 << (SB - 1)) - 1; tmin = -(1 << (SB - 1)); one = 1 << SFB;
    zero_mid = '{mx: '0, my: '0, mz: '0, ok: 1'b0};
    none     = zero_mid;

    // parallel tracks give zero and no solution
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_mid});
    dir_rows.push_back('{mk(5, -7, 9, 123, -45, 100, 200, -300, 123, -45), 1, zero_mid});
    dir_rows.push_back('{mk(pmax, pmin, pmax, tmax, tmin, pmin, pmax, pmin, tmax, tmin),
                         1, zero_mid});
    dir_rows.push_back('{mk(pmin, pmin, pmin, tmin, tmin, pmax, pmax, pmax, tmin, tmin),
                         1, zero_mid});
    // A along z through origin, B crossing it at z = 1000
    dir_rows.push_back('{mk(0, 0, 0, 0, 0, 1000, 0, 0, -one, 0), 1,
                         '{mx: pos_t'(0), my: pos_t'(0), mz: pos_t'(1000), ok: 1'b1}});
    // extremes and saturation, checked by calculation
    dir_rows.push_back('{mk(pmax, pmax, pmax, tmax, tmax, pmax, pmax, pmax, tmin, tmin), 0, none});
    dir_rows.push_back('{mk(pmin, pmin, pmin, tmin, tmax, pmin, pmin, pmin, tmax, tmin), 0, none});
    dir_rows.push_back('{mk(pmax, pmin, 0, tmax, 0, pmin, pmax, 0, tmax - 1, 0), 0, none});
    dir_rows.push_back('{mk(pmin, pmax, pmax, 1, 0, pmax, pmin, pmin, 0, 1), 0, none});
    dir_rows.push_back('{mk(-1, -1, -1, -1, -1, 0, 0, 0, 1, 1), 0, none});
    dir_rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, one, 0), 0, none});
    dir_rows.push_back('{mk(3, 1, 2, one, 0, 0, 0, 0, 0, one), 0, none});
    dir_rows.push_back('{mk(0, 0, pmax, tmin, tmin, 0, 0, pmin, tmax, tmax), 0, none});

    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (dir_rows[i]) send(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].r);
    repeat (N_RAND) send(rand_pair(), 1'b0, none);
    in_valid_i <= 1'b0;

    wait (midpoint_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("sent %0d track pairs (%0d directed), checked %0d midpoints, %0d parallel",
             n_sent, dir_rows.size(), n_seen, n_parallel);
    $display("random idling on both sides with one 400-cycle output hold-off");
    if (n_fail == 0) begin
      $display("tb_two_track_closest_approach_point_top OK");
    end else begin
      $display("tb_two_track_closest_approach_point_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tcap_pkg.sv
rtl/core/tcap_mul.sv
rtl/core/tcap_div.sv
rtl/core/two_track_closest_approach_point_top.sv
bench/tb_two_track_closest_approach_point_top.sv
